// ----- src/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int MAX_CODE_LEN    = 16;
  localparam int SYMBOL_COUNT    = 256;
  localparam int CODE_FIELD_BITS = 16;
  localparam int LEN_CAP         = (MAX_CODE_LEN < CODE_FIELD_BITS) ? MAX_CODE_LEN
                                                                     : CODE_FIELD_BITS;
  localparam int SYM_AW          = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam int OUTQ_DEPTH = 8;
  localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW      = OQ_AW + 1;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
  } hcbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } hcbp_out_t;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  len;
  } hcbp_entry_t;

  // Bytes produced by the packing stage in one cycle.
  typedef struct packed {
    logic [1:0] n;
    hcbp_out_t  b0;
    hcbp_out_t  b1;
  } hcbp_push_t;

endpackage

// ----- src/hcbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/hcbp_outq.sv -----
// Output byte queue: takes up to two bytes a cycle, delivers one beat a cycle on pop.
module hcbp_outq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hcbp_pkg::hcbp_push_t    push,
  input  logic                    pop,
  output logic                    head_vld,
  output hcbp_pkg::hcbp_out_t     head,
  output logic [hcbp_pkg::OQ_CW-1:0] cnt
);
  import hcbp_pkg::*;

  hcbp_out_t        q_r [OUTQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_AW-1:0] wr_p1;

  assign wr_p1    = wr_r + OQ_AW'(1);
  assign head_vld = (cnt_r != '0);
  assign head     = q_r[rd_r];
  assign cnt      = cnt_r;

  always_comb begin
    wr_nxt  = wr_r + OQ_AW'(push.n);
    rd_nxt  = pop ? rd_r + OQ_AW'(1) : rd_r;
    cnt_nxt = cnt_r + OQ_CW'(push.n) - (pop ? OQ_CW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.b0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_p1] <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/huffman_code_bit_packer.sv -----
// Huffman encoder back end: code table lookup and MSB-first byte packing.
//
// Input channel (in_valid/in_stall/in_data) carries load, encode and flush
// items. A load writes one code table entry, length capped at 16. An encode
// reads the symbol's entry and appends its code to the pending byte; a flush
// emits any partial byte. Output channel (out_valid/out_stall/out_data)
// carries packed bytes, with last set on the final byte of an item.
// Timing: the table is read when an item is accepted, packing follows in the
// next cycle, and the packed bytes go into the byte queue that drives out_*.
// Throughput: one item a cycle while in_stall is low; the output side drains
// one beat a cycle, so a stream of encodes each making two bytes is held back
// by in_stall, set by the single output port of the eight-entry byte queue.
// in_stall rises when the queue cannot take the worst case (two bytes) from
// the item in flight plus a new one; a stalled receiver therefore backs up
// into in_stall without losing beats.
// Reset clears the pending byte, its bit count and the queue; the code table
// is not cleared and must be loaded before use.
module huffman_code_bit_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hcbp_pkg::hcbp_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hcbp_pkg::hcbp_out_t  out_data
);
  import hcbp_pkg::*;

  logic              in_acc;
  logic              sym_ok;
  logic              tbl_we, tbl_re;
  hcbp_entry_t       wr_ent, rd_ent;

  logic              s1_vld_r;
  logic [1:0]        s1_op_r;
  logic              s1_ok_r;

  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic [2:0]        pend_cnt_r, pend_cnt_nxt;

  hcbp_push_t        push;
  logic [OQ_CW-1:0]  oq_cnt;
  logic [OQ_CW:0]    credit;

  logic [4:0]        len;
  logic [15:0]       code_m;
  logic [4:0]        tot;
  logic [4:0]        sh;
  logic [23:0]       w;

  assign in_acc = in_valid && !in_stall;
  assign sym_ok = (32'(in_data.symbol) < SYMBOL_COUNT);

  always_comb begin
    wr_ent.code = in_data.code_bits;
    wr_ent.len  = (32'(in_data.code_length) > LEN_CAP) ? 5'(LEN_CAP) : in_data.code_length;
  end

  assign tbl_we = in_acc && (in_data.opcode == OP_LOAD) && sym_ok;
  assign tbl_re = in_acc && (in_data.opcode == OP_ENCODE);

  hcbp_ram #(
    .WIDTH($bits(hcbp_entry_t)),
    .DEPTH(SYMBOL_COUNT)
  ) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(in_data.symbol[SYM_AW-1:0]),
    .wdata(wr_ent),
    .re   (tbl_re),
    .raddr(in_data.symbol[SYM_AW-1:0]),
    .rdata(rd_ent)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc && (in_data.opcode == OP_ENCODE || in_data.opcode == OP_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= in_data.opcode;
    s1_ok_r <= sym_ok;
  end

  // Packing: pending bits on top, then the code, zero filled below.
  always_comb begin
    len    = s1_ok_r ? rd_ent.len : 5'd0;
    code_m = rd_ent.code & 16'((17'd1 << len) - 17'd1);
    tot    = {2'b0, pend_cnt_r} + len;
    sh     = 5'd24 - tot;
    w      = {pend_byte_r, 16'b0} | (24'(code_m) << sh);
  end

  always_comb begin
    pend_byte_nxt = pend_byte_r;
    pend_cnt_nxt  = pend_cnt_r;
    push          = '0;
    if (s1_vld_r) begin
      unique case (s1_op_r)
        OP_ENCODE: begin
          pend_cnt_nxt   = tot[2:0];
          push.n         = tot[4:3];
          push.b0.out_byte = w[23:16];
          push.b0.last   = (tot[4:3] == 2'd1);
          push.b1.out_byte = w[15:8];
          push.b1.last   = 1'b1;
          case (tot[4:3])
            2'd0:    pend_byte_nxt = w[23:16];
            2'd1:    pend_byte_nxt = w[15:8];
            default: pend_byte_nxt = w[7:0];
          endcase
        end
        OP_FLUSH: begin
          if (pend_cnt_r != 3'd0) begin
            push.n           = 2'd1;
            push.b0.out_byte = pend_byte_r;
            push.b0.last     = 1'b1;
            pend_byte_nxt    = 8'd0;
            pend_cnt_nxt     = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_byte_r <= 8'd0;
      pend_cnt_r  <= 3'd0;
    end else begin
      pend_byte_r <= pend_byte_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  hcbp_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (out_valid && !out_stall),
    .head_vld(out_valid),
    .head    (out_data),
    .cnt     (oq_cnt)
  );

  // Keep room for two bytes from the item in flight and two from a new one.
  assign credit   = {1'b0, oq_cnt} + (s1_vld_r ? (OQ_CW+1)'(2) : '0);
  assign in_stall = (credit > (OQ_CW+1)'(OUTQ_DEPTH - 2));

endmodule

// ----- src/hcbp_checker.sv -----
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hcbp_pkg::hcbp_out_t out_data
);
  import hcbp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // A non-final byte is always queued together with its follower.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("second byte of a pair missing");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
